// ===== rtl/otd_pkg.sv =====
// Shared types and constants of the oscillation turn detector.
package otd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 15;
  localparam int TURNS_W  = 9;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam logic [TURNS_W-1:0] TURN_COUNT_MAX = 9'd511;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  // register indexes
  localparam logic CFG_MIN_AMPLITUDE = 1'b0;
  localparam logic CFG_ON_TURNS      = 1'b1;

  typedef struct packed {
    logic [AMP_W-1:0]   min_amplitude;
    logic [TURNS_W-1:0] on_turns;
  } cfg_t;

  typedef struct packed {
    logic [TURNS_W-1:0] turn_count;
    logic               count_valid;
    logic               detecting;
    logic [1:0]         event_kind;
  } result_t;

endpackage

// ===== rtl/oscillation_turn_detector.sv =====
// Top level of the oscillation turn detector: config registers, front, queue, back.
module oscillation_turn_detector #(
  parameter int WINDOW = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  otd_pkg::sample_t               angle_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [otd_pkg::TURNS_W-1:0]    turn_count,
  output logic                           count_valid,
  output logic                           detecting,
  output logic [1:0]                     event_kind,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [otd_pkg::AMP_W-1:0]      cfg_data
);
  // Each angle sample request goes into a circular window of the last WINDOW
  // samples and gives exactly one result. Until the window is full a result
  // (count_valid 0, turn_count 0) goes through the queue to the output register.
  // Once full, every sample rewalks the whole window oldest to newest through
  // the single read port of the sample memory: one entry per cycle, and the back
  // end takes no other request until the walk ends. A two-entry queue lets the
  // front end take up to two more requests while a walk runs, and a finished
  // result waits in the output register; the back end starts no new request
  // until it is taken. Turns are direction changes whose swing from the
  // last counted turn exceeds min_amplitude; a zero step counts as rising. The
  // detect flag sets when the count exceeds on_turns (event 1) and clears when a
  // valid count is zero (event 2). Counts above 511 saturate on turn_count only.
  // The sample memory needs no clearing: it is read only after every slot holds a
  // sample. Configuration writes take effect at once and belong in idle periods.
  import otd_pkg::*;

  localparam int AW    = $clog2(WINDOW);
  localparam int JOB_W = SAMPLE_W + AW + 1;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_amplitude <= 15'd357;
      cfg.on_turns      <= 9'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_AMPLITUDE: cfg.min_amplitude <= cfg_data;
        CFG_ON_TURNS:      cfg.on_turns      <= cfg_data[TURNS_W-1:0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  // front end -> queue
  logic           q_ready;
  logic           q_push;
  sample_t        f_sample;
  logic [AW-1:0]  f_ptr;
  logic           f_full;

  otd_front #(.WINDOW(WINDOW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .angle_sample (angle_sample),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .job_sample   (f_sample),
    .job_ptr      (f_ptr),
    .job_full     (f_full)
  );

  // queue -> back end
  logic             b_valid;
  logic             b_pop;
  logic [JOB_W-1:0] b_job;

  otd_queue #(.DATA_W(JOB_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({f_sample, f_ptr, f_full}),
    .push_ready (q_ready),
    .pop        (b_pop),
    .pop_valid  (b_valid),
    .pop_data   (b_job)
  );

  result_t res;

  otd_back #(.WINDOW(WINDOW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (b_valid),
    .job_pop    (b_pop),
    .job_sample (b_job[JOB_W-1 -: SAMPLE_W]),
    .job_ptr    (b_job[AW:1]),
    .job_full   (b_job[0]),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign turn_count  = res.turn_count;
  assign count_valid = res.count_valid;
  assign detecting   = res.detecting;
  assign event_kind  = res.event_kind;

endmodule

// ===== rtl/otd_front.sv =====
// Front end: accepts samples, tracks window slot and fill, builds walk requests.
module otd_front #(
  parameter int WINDOW = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  otd_pkg::sample_t          angle_sample,
  input  logic                      q_ready,
  output logic                      q_push,
  output otd_pkg::sample_t          job_sample,
  output logic [$clog2(WINDOW)-1:0] job_ptr,
  output logic                      job_full
);
  import otd_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);

  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] fill;

  assign in_ready   = q_ready;
  assign q_push     = in_valid && q_ready;
  assign job_sample = angle_sample;
  assign job_ptr    = wr_ptr;
  // window is full once this sample lands
  assign job_full   = (fill >= CW'(WINDOW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      fill   <= '0;
    end else if (q_push) begin
      wr_ptr <= (wr_ptr == AW'(WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
      if (fill != CW'(WINDOW)) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/otd_queue.sv =====
// Two-entry request queue between front and back.
module otd_queue #(
  parameter int DATA_W = 26
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);
  logic [DATA_W-1:0] slots [2];
  logic              wp;
  logic              rp;
  logic [1:0]        count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rp];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wp <= ~wp;
      end
      if (pop && pop_valid) begin
        rp <= ~rp;
      end
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/otd_back.sv =====
// Back end: sample store, window walk, turn count, detect flag and result register.
module otd_back #(
  parameter int WINDOW = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  otd_pkg::cfg_t             cfg,
  input  logic                      job_valid,
  output logic                      job_pop,
  input  otd_pkg::sample_t          job_sample,
  input  logic [$clog2(WINDOW)-1:0] job_ptr,
  input  logic                      job_full,
  output logic                      res_valid,
  input  logic                      res_ready,
  output otd_pkg::result_t          res
);
  import otd_pkg::*;

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int CMPW = (CW > TURNS_W) ? CW : TURNS_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  sample_t        mem [WINDOW];
  sample_t        rd_data;
  logic           state;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  rd_cnt;
  logic           dv;
  logic [CW-1:0]  di;
  sample_t        prev;
  sample_t        last_turn;
  logic           dir;
  logic [CW-1:0]  cnt;
  logic           flag;

  logic              issue;
  logic              last_elem;
  logic              s;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0] mag;
  logic              is_turn;
  logic              counted;
  logic [CW-1:0]     cnt_next;
  logic [CMPW-1:0]   cnt_w;
  logic              set_det;
  logic              clr_det;

  assign job_pop   = (state == ST_IDLE) && job_valid && (!res_valid || res_ready);
  assign issue     = (state == ST_WALK) && (rd_cnt != CW'(WINDOW));
  assign last_elem = dv && (di == CW'(WINDOW - 1));

  always_comb begin
    s        = (rd_data >= prev);
    diff     = {last_turn[SAMPLE_W-1], last_turn} - {rd_data[SAMPLE_W-1], rd_data};
    mag      = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
    is_turn  = (di > CW'(1)) && (s != dir);
    counted  = is_turn && (mag > {2'b00, cfg.min_amplitude});
    cnt_next = counted ? cnt + 1'b1 : cnt;
    cnt_w    = CMPW'(cnt_next);
    set_det  = !flag && (cnt_w > CMPW'(cfg.on_turns));
    clr_det  = flag && (cnt_next == '0);
  end

  // sample store: write on request entry, one read per walk cycle
  always_ff @(posedge clk) begin
    if (job_pop) begin
      mem[job_ptr] <= job_sample;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      rd_addr <= (job_ptr == AW'(WINDOW - 1)) ? '0 : job_ptr + 1'b1;
      rd_cnt  <= '0;
    end else if (issue) begin
      rd_addr <= (rd_addr == AW'(WINDOW - 1)) ? '0 : rd_addr + 1'b1;
      rd_cnt  <= rd_cnt + 1'b1;
    end
    di <= rd_cnt;
    if (dv) begin
      prev <= rd_data;
      if (di == '0) begin
        last_turn <= rd_data;
      end else if (di == CW'(1)) begin
        dir <= s;
      end else begin
        if (is_turn) begin
          dir <= s;
        end
        if (counted) begin
          last_turn <= rd_data;
        end
      end
    end
    if (job_pop && !job_full) begin
      res.turn_count  <= '0;
      res.count_valid <= 1'b0;
      res.detecting   <= flag;
      res.event_kind  <= EV_NONE;
    end else if (last_elem) begin
      res.turn_count  <= (cnt_w > CMPW'(TURN_COUNT_MAX)) ? TURN_COUNT_MAX
                                                        : cnt_w[TURNS_W-1:0];
      res.count_valid <= 1'b1;
      res.detecting   <= set_det ? 1'b1 : (clr_det ? 1'b0 : flag);
      res.event_kind  <= set_det ? EV_START : (clr_det ? EV_STOP : EV_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dv        <= 1'b0;
      cnt       <= '0;
      flag      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      dv <= issue;
      if (job_pop) begin
        cnt <= '0;
        if (job_full) begin
          state <= ST_WALK;
        end
      end else if (dv) begin
        cnt <= cnt_next;
      end
      if (last_elem) begin
        state <= ST_IDLE;
        if (set_det) begin
          flag <= 1'b1;
        end else if (clr_det) begin
          flag <= 1'b0;
        end
      end
      if ((job_pop && !job_full) || last_elem) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_dv_in_walk: assert property (@(posedge clk) disable iff (rst)
    dv |-> state == ST_WALK) else $error("read data outside walk");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    last_elem |=> res_valid && state == ST_IDLE) else $error("walk end without result");

  a_walk_out_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> !res_valid) else $error("result pending during walk");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> rd_cnt <= CW'(WINDOW)) else $error("read count overrun");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the oscillation turn detector.
module tb_top;
  import otd_pkg::*;

  localparam int WINDOW = 512;
  // the block rewalks the whole window per request; used for the quiet time at the end
  localparam int WALK_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  sample_t            angle_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [TURNS_W-1:0] turn_count;
  logic               count_valid;
  logic               detecting;
  logic [1:0]         event_kind;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_MIN_AMPLITUDE;
  logic [AMP_W-1:0]   cfg_data = '0;

  oscillation_turn_detector #(.WINDOW(WINDOW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .angle_sample(angle_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .turn_count(turn_count), .count_valid(count_valid),
    .detecting(detecting), .event_kind(event_kind),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the sample history, detect flag and registers
  // ---------------------------------------------------------------------------
  int      angle_hist [WINDOW];
  int      hist_wptr      = 0;
  int      hist_fill      = 0;
  bit      osc_flag       = 1'b0;
  int      model_min_amp  = 357;
  int      model_on_turns = 3;

  result_t turn_reports_due [$];   // expected results, oldest first
  int      samples_taken = 0;      // requests accepted so far
  int      mismatches    = 0;

  // per-request side info from the driver: directed rows carry a typed-in result
  bit      use_typed = 1'b0;
  result_t typed_report = '0;

  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  sample_t angle_plan [$];

  // Walk the window oldest to newest and count direction reversals whose
  // swing from the last counted reversal beats the minimum amplitude.
  function automatic int count_window_turns();
    int idx, prev, cur, last_turn, swing, turns;
    bit rising, up_now;
    idx       = hist_wptr;
    prev      = angle_hist[idx];
    last_turn = prev;
    turns     = 0;
    // zero step counts as upward
    rising    = angle_hist[(idx + 1) % WINDOW] >= prev;
    for (int k = 1; k < WINDOW; k++) begin
      idx    = (idx + 1) % WINDOW;
      cur    = angle_hist[idx];
      up_now = cur >= prev;
      if (up_now != rising) begin
        swing  = last_turn - cur;
        if (swing < 0) swing = -swing;
        rising = up_now;
        if (swing > model_min_amp) begin
          turns++;
          last_turn = cur;
        end
      end
      prev = cur;
    end
    return turns;
  endfunction

  // Take one sample into the history and work out the result it causes.
  function automatic result_t track_sample(sample_t s);
    result_t r;
    int      turns;
    angle_hist[hist_wptr] = int'(s);
    hist_wptr = (hist_wptr + 1) % WINDOW;
    if (hist_fill < WINDOW) hist_fill++;
    r = '0;
    r.event_kind = EV_NONE;
    // no count, and no flag change, until the window is full
    if (hist_fill == WINDOW) begin
      turns = count_window_turns();
      r.count_valid = 1'b1;
      r.turn_count  = (turns > int'(TURN_COUNT_MAX)) ? TURN_COUNT_MAX : turns[TURNS_W-1:0];
      if (!osc_flag && turns > model_on_turns) begin
        osc_flag     = 1'b1;
        r.event_kind = EV_START;
      end else if (osc_flag && turns == 0) begin
        osc_flag     = 1'b0;
        r.event_kind = EV_STOP;
      end
    end
    r.detecting = osc_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge; inputs move on the falling
  // edge, so nothing here depends on event order inside the time step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want, got;
    if (!rst) begin
      if (cfg_we) begin
        // bits above each register's width are dropped
        case (cfg_index)
          CFG_MIN_AMPLITUDE: model_min_amp  = int'(cfg_data);
          CFG_ON_TURNS:      model_on_turns = int'(cfg_data[TURNS_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = track_sample(angle_sample);
        if (use_typed) want = typed_report;
        turn_reports_due = {turn_reports_due, want};
        samples_taken <= samples_taken + 1;
      end
      if (out_valid && out_ready) begin
        got = '{turn_count: turn_count, count_valid: count_valid,
                detecting: detecting, event_kind: event_kind};
        if (turn_reports_due.size() == 0) begin
          $error("result with none expected: turn_count %0d count_valid %0d %s",
                 got.turn_count, got.count_valid,
                 $sformatf("detecting %0d event_kind %0d", got.detecting, got.event_kind));
          mismatches++;
        end else begin
          want = turn_reports_due.pop_front();
          if (got.turn_count !== want.turn_count) begin
            $error("turn_count: expected %0d, actual %0d", want.turn_count, got.turn_count);
            mismatches++;
          end
          if (got.count_valid !== want.count_valid) begin
            $error("count_valid: expected %0d, actual %0d", want.count_valid, got.count_valid);
            mismatches++;
          end
          if (got.detecting !== want.detecting) begin
            $error("detecting: expected %0d, actual %0d", want.detecting, got.detecting);
            mismatches++;
          end
          if (got.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driver helpers (all called on a falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_sample(sample_t s, bit typed, result_t typed_val);
    int target;
    // random sender gaps; valid only drops between requests
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    angle_sample = s;
    use_typed    = typed;
    typed_report = typed_val;
    target       = samples_taken + 1;
    while (samples_taken != target) @(negedge clk);
  endtask

  task automatic wait_drained(int extra);
    while (turn_reports_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [AMP_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic sample_t to_angle(int v);
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  // Fill angle_plan with n samples built from random segments: oscillations
  // around the current minimum amplitude, ramps, holds, jitter, full-range
  // noise and rail-to-rail swings (which a maximal threshold still counts).
  task automatic plan_angles(int n);
    int  kind, len, base, amp, half, step, v, jit;
    bit  up;
    angle_plan.delete();
    while (angle_plan.size() < n) begin
      kind = $urandom_range(11);
      len  = $urandom_range(6, 90);
      base = int'($urandom_range(65535)) - 32768;
      case (kind)
        0, 1, 2, 3, 4: begin
          case ($urandom_range(3))
            0:       amp = $urandom_range(model_min_amp);
            3:       amp = $urandom_range(65535);
            default: amp = model_min_amp + $urandom_range(2000);
          endcase
          half = $urandom_range(1, 10);
          step = amp / half;
          v    = base;
          up   = $urandom_range(1);
          for (int k = 0; k < len; k++) begin
            angle_plan = {angle_plan, to_angle(v)};
            v = up ? v + step : v - step;
            if ((k + 1) % half == 0) up = !up;
          end
        end
        5: begin
          step = int'($urandom_range(600)) - 300;
          for (int k = 0; k < len; k++) angle_plan = {angle_plan, to_angle(base + k * step)};
        end
        6: begin
          // long holds let a window go quiet
          if ($urandom_range(3) == 0) len = $urandom_range(100, 300);
          for (int k = 0; k < len; k++) angle_plan = {angle_plan, to_angle(base)};
        end
        7: begin
          for (int k = 0; k < len; k++)
            angle_plan = {angle_plan, sample_t'($urandom_range(65535))};
        end
        8, 9: begin
          jit = model_min_amp;
          for (int k = 0; k < len; k++)
            angle_plan = {angle_plan, to_angle(base + int'($urandom_range(jit)))};
        end
        default: begin
          up = $urandom_range(1);
          len = $urandom_range(2, 6);
          for (int k = 0; k < len; k++) begin
            angle_plan = {angle_plan, (up ? sample_t'(16'sh7fff) : sample_t'(16'sh8000))};
            up = !up;
          end
        end
      endcase
    end
    while (angle_plan.size() > n) void'(angle_plan.pop_back());
  endtask

  // Directed rows: all land while the window is still filling, so each one
  // must come back with no count, no detection and no event.
  typedef struct packed {
    sample_t angle;
    result_t want;
  } directed_row_t;

  localparam result_t FILLING = '{turn_count: '0, count_valid: 1'b0,
                                  detecting: 1'b0, event_kind: EV_NONE};

  localparam directed_row_t DIRECTED [25] = '{
    '{-16'sd32768, FILLING}, '{16'sd32767, FILLING}, '{16'sd0, FILLING},
    '{-16'sd1, FILLING},     '{16'sd1, FILLING},     '{16'sh5555, FILLING},
    '{-16'sd21846, FILLING}, '{16'sd0, FILLING},     '{16'sd0, FILLING},
    '{16'sd0, FILLING},      '{16'sd32767, FILLING}, '{16'sd32767, FILLING},
    '{-16'sd32768, FILLING}, '{-16'sd32768, FILLING}, '{16'sd357, FILLING},
    '{16'sd358, FILLING},    '{-16'sd357, FILLING},  '{16'sd100, FILLING},
    '{16'sd200, FILLING},    '{16'sd100, FILLING},   '{16'sd200, FILLING},
    '{16'sd100, FILLING},    '{16'sd12345, FILLING}, '{-16'sd12345, FILLING},
    '{16'sd0, FILLING}
  };

  localparam int PHASES     = 14;
  localparam int PHASE_REQS = 45;
  localparam int FILL_REQS  = 490;

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int               amp_set, on_set;
    logic [AMP_W-1:0] on_word;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed rows at reset configuration, no idling
    foreach (DIRECTED[i]) send_sample(DIRECTED[i].angle, 1'b1, DIRECTED[i].want);

    // fill the window under the reset registers, sender idling
    send_idle_pct = 64;
    plan_angles(FILL_REQS);
    foreach (angle_plan[i]) send_sample(angle_plan[i], 1'b0, FILLING);
    in_valid = 1'b0;

    // short phases with new register settings: every change of threshold
    // tends to start or stop detection on the next full-window count
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained(8);
      case (ph)
        0: begin amp_set = 0;     on_set = 0;   end
        1: begin amp_set = 32767; on_set = 511; end
        2: begin amp_set = 0;     on_set = 511; end
        3: begin amp_set = 32767; on_set = 0;   end
        default: begin
          case ($urandom_range(3))
            0:       amp_set = $urandom_range(400);
            1:       amp_set = $urandom_range(3000);
            2:       amp_set = $urandom_range(32767);
            default: amp_set = 357;
          endcase
          case ($urandom_range(3))
            0:       on_set = 0;
            1:       on_set = $urandom_range(8);
            2:       on_set = $urandom_range(60);
            default: on_set = $urandom_range(511);
          endcase
        end
      endcase
      // junk in the bits above the on_turns width must be dropped
      on_word = (AMP_W'($urandom_range(32767)) & ~AMP_W'(9'h1ff)) | AMP_W'(on_set);
      write_reg(CFG_MIN_AMPLITUDE, AMP_W'(amp_set));
      write_reg(CFG_ON_TURNS, on_word);

      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 64; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      plan_angles(PHASE_REQS);
      foreach (angle_plan[i]) send_sample(angle_plan[i], 1'b0, FILLING);
      in_valid = 1'b0;
    end

    // drain, then stay quiet long enough to catch any stray result
    wait_drained(WALK_CYCLES);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // hang guard: several times the slowest legal run
  initial begin : watchdog
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/otd_pkg.sv
rtl/otd_front.sv
rtl/otd_queue.sv
rtl/otd_back.sv
rtl/oscillation_turn_detector.sv
test/tb_top.sv
